@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/crl_pkg.sv @@
// ----------------------------------------------------------------------------
// crl_pkg
// Types, character codes and classification helpers for the recogniser.
// ----------------------------------------------------------------------------
package crl_pkg;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_ZERO  = 4'd1,
        PH_OCT   = 4'd2,
        PH_DEC   = 4'd3,
        PH_HEXP  = 4'd4,
        PH_HEX   = 4'd5,
        PH_U     = 4'd6,
        PH_UL1   = 4'd7,
        PH_DONE  = 4'd8,
        PH_L1    = 4'd9,
        PH_LL    = 4'd10
    } lex_phase_t;

    typedef struct packed {
        lex_phase_t phase;
        logic       long_upper;
        logic       rejected;
    } lex_state_t;

    localparam lex_state_t LEX_STATE_RESET = '{phase: PH_START, long_upper: 1'b0,
                                               rejected: 1'b0};

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_7    = 8'h37;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_L_UP = 8'h4C;
    localparam logic [7:0] CH_U_UP = 8'h55;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_L_LO = 8'h6C;
    localparam logic [7:0] CH_U_LO = 8'h75;
    localparam logic [7:0] CH_X_LO = 8'h78;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_A_LO) && (c <= CH_F_LO)) ||
               ((c >= CH_A_UP) && (c <= CH_F_UP));
    endfunction

    function automatic logic is_u(input logic [7:0] c);
        return (c == CH_U_LO) || (c == CH_U_UP);
    endfunction

    function automatic logic is_l(input logic [7:0] c);
        return (c == CH_L_LO) || (c == CH_L_UP);
    endfunction

    // True when the token may legally end in this phase.
    function automatic logic phase_accepts(input lex_phase_t p);
        return (p != PH_START) && (p != PH_HEXP);
    endfunction

endpackage

@@ design/crl_step.sv @@
// ----------------------------------------------------------------------------
// crl_step
// One transition of the recogniser: current state and character in, next
// state and the verdict for a token ending on this character out.
// ----------------------------------------------------------------------------
module crl_step
    import crl_pkg::*;
(
    input  lex_state_t cur,
    input  logic [7:0] ch,
    output lex_state_t nxt,
    output logic       accepted
);

    lex_state_t suffix;
    logic       same_long;

    // First suffix letter straight after the digits.
    always_comb
    begin
        suffix = cur;
        if (is_u(ch))
        begin
            suffix.phase = PH_U;
        end
        else if (is_l(ch))
        begin
            suffix.phase      = PH_L1;
            suffix.long_upper = (ch == CH_L_UP);
        end
        else
        begin
            suffix.rejected = 1'b1;
        end
    end

    assign same_long = (ch == (cur.long_upper ? CH_L_UP : CH_L_LO));

    always_comb
    begin
        nxt = cur;
        if (!cur.rejected)
        begin
            case (cur.phase)
                PH_START:
                begin
                    if (ch == CH_0)
                        nxt.phase = PH_ZERO;
                    else if ((ch >= CH_1) && (ch <= CH_9))
                        nxt.phase = PH_DEC;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_ZERO:
                begin
                    if ((ch == CH_X_LO) || (ch == CH_X_UP))
                        nxt.phase = PH_HEXP;
                    else if (is_oct(ch))
                        nxt.phase = PH_OCT;
                    else
                        nxt = suffix;
                end
                PH_OCT:
                begin
                    if (!is_oct(ch))
                        nxt = suffix;
                end
                PH_DEC:
                begin
                    if (!is_dec(ch))
                        nxt = suffix;
                end
                PH_HEXP:
                begin
                    if (is_hex(ch))
                        nxt.phase = PH_HEX;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_HEX:
                begin
                    if (!is_hex(ch))
                        nxt = suffix;
                end
                PH_U:
                begin
                    if (is_l(ch))
                    begin
                        nxt.phase      = PH_UL1;
                        nxt.long_upper = (ch == CH_L_UP);
                    end
                    else
                    begin
                        nxt.rejected = 1'b1;
                    end
                end
                PH_UL1:
                begin
                    if (same_long)
                        nxt.phase = PH_DONE;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_L1:
                begin
                    if (same_long)
                        nxt.phase = PH_LL;
                    else if (is_u(ch))
                        nxt.phase = PH_DONE;
                    else
                        nxt.rejected = 1'b1;
                end
                PH_LL:
                begin
                    if (is_u(ch))
                        nxt.phase = PH_DONE;
                    else
                        nxt.rejected = 1'b1;
                end
                default:
                begin
                    nxt.rejected = 1'b1;
                end
            endcase
        end
    end

    assign accepted = !nxt.rejected && phase_accepts(nxt.phase);

endmodule

@@ design/c_integer_literal_recognizer_core.sv @@
// ----------------------------------------------------------------------------
// c_integer_literal_recognizer_core
// Scans candidate tokens one character per transaction and reports whether
// each complete token is a valid C integer literal.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ------------------------------------------------------
//  s_*      in         tdata[7:0] = ch, tlast = last (final character)
//  m_*      out        tdata[0] = accepted, tdata[7:1] = 0; one per token
//
// A character is taken into an input register and from there, once it may
// advance, passes through the transition logic into the recogniser state and,
// for a final character, into the result register: one character per cycle
// while no final character waits for the result slot.
// Reset puts the recogniser at the start of a token and empties both registers.
// While a verdict waits on m_tready, characters that are not final keep moving;
// a final character waits in the input register until the result slot frees.
//
`include "assert_macros.svh"

module c_integer_literal_recognizer_core
    import crl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] accepted, [7:1] zero
);

    // Input register holding the character awaiting its transition.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       last_reg;

    // Recogniser state carried from one character of a token to the next.
    lex_state_t state_reg, state_next;
    lex_state_t step_state;
    logic       step_accepted;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic accepted_reg;

    logic out_space;
    logic proc;
    logic in_fire;

    // The result slot can take a verdict if it is empty or draining this cycle.
    assign out_space = !out_valid_reg || m_tready;

    // A character advances unless it is final and the result slot is full.
    assign proc     = in_valid_reg && (!last_reg || out_space);
    assign s_tready = !in_valid_reg || proc;
    assign in_fire  = s_tvalid && s_tready;

    crl_step u_step (
        .cur      (state_reg),
        .ch       (ch_reg),
        .nxt      (step_state),
        .accepted (step_accepted)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
    end

    // The final character of a token sends the recogniser back to its start.
    always_comb
    begin
        state_next = state_reg;
        if (proc)
            state_next = last_reg ? LEX_STATE_RESET : step_state;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc && last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
        if (proc && last_reg)
            accepted_reg <= step_accepted;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, accepted_reg};

    // A verdict is never written over one that has not yet been taken.
    `ASSERT_SAME(a_no_overwrite, proc && last_reg, out_space,
                 "verdict would overwrite a pending result")

    // After a final character the recogniser is back at the start of a token.
    `ASSERT_NEXT(a_token_restart, proc && last_reg,
                 state_reg == LEX_STATE_RESET,
                 "recogniser not restarted after final character")

    // Once a token has failed, it stays failed until its final character.
    `ASSERT_NEXT(a_reject_sticky, state_reg.rejected && !(proc && last_reg),
                 state_reg.rejected,
                 "failed token recovered before its final character")

endmodule
